/* rtl/core/spmc_pkg.sv */
// ----------------------------------------------------------------------------
// spmc_pkg
// Shared constants, types and symmetry tables of the pivot move checker.
// ----------------------------------------------------------------------------
package spmc_pkg;

  localparam int MAX_STEPS  = 256;
  localparam int COORD_BITS = 10;
  localparam int STEP_AW    = $clog2(MAX_STEPS);
  localparam int LEN_W      = STEP_AW + 1;
  localparam int CODE_W     = 3;
  localparam int SYM_W      = 5;
  localparam int DIM_W      = 3;
  localparam int NUM_AXES   = 4;
  localparam int KEY_W      = NUM_AXES * COORD_BITS;
  // The position set never holds more than MAX_STEPS + 1 keys, so a table
  // of twice MAX_STEPS entries is never more than one entry past half full.
  localparam int HASH_AW    = STEP_AW + 1;
  localparam int HASH_DEPTH = 2 ** HASH_AW;
  localparam int EPOCH_W    = 8;
  localparam int HENT_W     = EPOCH_W + KEY_W;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TRIAL = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  localparam logic [1:0] CFG_DIMENSION   = 2'd0;
  localparam logic [1:0] CFG_WALK_LENGTH = 2'd1;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_EXEC,
    S_RD_WAIT,
    S_SCAN_RD,
    S_SCAN_CK,
    S_HASH,
    S_P_RD,
    S_P_CK,
    S_WSEL,
    S_WMOVE,
    S_C_RD,
    S_C_WR,
    S_DONE
  } spmc_state_e;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] pos_t;

  // Each row holds the new code of a positive step along axes 0..3, one
  // octal digit per axis with axis 0 in the lowest digit.
  localparam logic [11:0] SYM_MAP2 [4] = '{12'o0030, 12'o0021, 12'o0003, 12'o0012};
  localparam logic [11:0] SYM_MAP3 [12] = '{
    12'o0520, 12'o0421, 12'o0430, 12'o0250, 12'o0530, 12'o0340,
    12'o0025, 12'o0521, 12'o0124, 12'o0412, 12'o0431, 12'o0403};
  localparam logic [11:0] SYM_MAP4 [22] = '{
    12'o7420, 12'o6520, 12'o6430, 12'o6421, 12'o4720, 12'o7520, 12'o5620,
    12'o2470, 12'o7430, 12'o3460, 12'o6250, 12'o6530, 12'o6340,
    12'o0427, 12'o7421, 12'o1426, 12'o6025, 12'o6521, 12'o6124,
    12'o6403, 12'o6431, 12'o6412};

  localparam logic [SYM_W-1:0] INV2 [4] = '{5'd0, 5'd1, 5'd3, 5'd2};
  localparam logic [SYM_W-1:0] INV3 [12] = '{
    5'd0, 5'd1, 5'd2, 5'd5, 5'd4, 5'd3, 5'd8, 5'd7, 5'd6, 5'd11, 5'd10, 5'd9};
  localparam logic [SYM_W-1:0] INV4 [22] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd6, 5'd5, 5'd4, 5'd9, 5'd8, 5'd7, 5'd12, 5'd11,
    5'd10, 5'd15, 5'd14, 5'd13, 5'd18, 5'd17, 5'd16, 5'd21, 5'd20, 5'd19};

  function automatic logic [SYM_W-1:0] sym_count(logic [DIM_W-1:0] dim);
    logic [SYM_W-1:0] n;
    case (dim)
      3'd2:    n = 5'd4;
      3'd3:    n = 5'd12;
      3'd4:    n = 5'd22;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [CODE_W-1:0] map_step(logic [DIM_W-1:0] dim,
                                                 logic [SYM_W-1:0] sym,
                                                 logic [CODE_W-1:0] code);
    logic [11:0] row;
    logic [CODE_W-1:0] base;
    case (dim)
      3'd2:    row = SYM_MAP2[sym[1:0]];
      3'd3:    row = SYM_MAP3[(sym < 5'd12) ? sym[3:0] : 4'd0];
      default: row = SYM_MAP4[(sym < 5'd22) ? sym : 5'd0];
    endcase
    base = row[code[2:1]*CODE_W +: CODE_W];
    return base ^ {2'b00, code[0]};
  endfunction

  function automatic logic [SYM_W-1:0] inv_sym(logic [DIM_W-1:0] dim,
                                               logic [SYM_W-1:0] sym);
    logic [SYM_W-1:0] r;
    case (dim)
      3'd2:    r = INV2[sym[1:0]];
      3'd3:    r = INV3[(sym < 5'd12) ? sym[3:0] : 4'd0];
      default: r = INV4[(sym < 5'd22) ? sym : 5'd0];
    endcase
    return r;
  endfunction

  function automatic pos_t move_pos(pos_t p, logic [CODE_W-1:0] code, logic backward);
    pos_t r;
    r = p;
    if (code[0] ^ backward) begin
      r[code[2:1]] = p[code[2:1]] - coord_t'(1);
    end else begin
      r[code[2:1]] = p[code[2:1]] + coord_t'(1);
    end
    return r;
  endfunction

  // Folds the packed coordinates into a table address; each axis is
  // rotated differently so that neighboring sites spread out.
  function automatic logic [HASH_AW-1:0] hash_key(pos_t p);
    logic [HASH_AW-1:0] h;
    h = '0;
    for (int c = 0; c < NUM_AXES; c++) begin
      for (int b = 0; b < COORD_BITS; b++) begin
        h[(b + 3 * c) % HASH_AW] = h[(b + 3 * c) % HASH_AW] ^ p[c][b];
      end
    end
    return h;
  endfunction

endpackage

/* rtl/core/spmc_ram.sv */
// ----------------------------------------------------------------------------
// spmc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module spmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/core/saw_pivot_move_checker.sv */
// ----------------------------------------------------------------------------
// saw_pivot_move_checker
// Stores a self-avoiding lattice walk and checks and commits pivot moves.
// ----------------------------------------------------------------------------
// Usage: each word on the s_axis channel carries one operation. A load writes
// one step code, a read returns one, and a pivot trial applies a symmetry to
// all steps from the pivot site on, rebuilds both arms of the walk around the
// pivot point and commits the new steps only if no site repeats. Every input
// word yields exactly one result word on m_axis with a status, the inverse
// symmetry for undo and the read step code.
// A trial first screens every step, then visits the sites of both arms of the
// walk in turn with one or more hash probes per site, then rewrites the
// steps from the pivot site on. The walk and the visited-site hash table each
// sit in a one-port-read RAM, and every step costs one step read and at least
// one table read.
// One word is worked on at a time; the next word is taken as soon as the
// current one has reached the output register, even if that word still waits
// for the receiver. A stalled receiver holds the block in its final state
// until the output register frees up.
// After reset a clearing pass zeroes the walk and the table before the first
// word is accepted. The same pass, without touching the walk, runs once every
// 255 trials that pass the step screening, when the table epoch wraps around.
// The configuration channel is always ready and must only be written idle.
// ----------------------------------------------------------------------------
module saw_pivot_move_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // operation[1:0], index[9:2], direction[12:10], symmetry[17:13]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  // status[1:0], inverse_symmetry[6:2], read_direction[9:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  import spmc_pkg::*;

  spmc_state_e state_q, state_d;

  // Configuration registers.
  logic [DIM_W-1:0] dim_q;
  logic [LEN_W-1:0] wlen_q;

  // Captured input word.
  op_e               op_q, op_d;
  logic [STEP_AW-1:0] idx_q, idx_d;
  logic [CODE_W-1:0] dir_q, dir_d;
  logic [SYM_W-1:0]  sym_q, sym_d;

  // Sequencer counters and walk state.
  logic [HASH_AW-1:0] clr_q, clr_d;
  logic               clr_steps_q, clr_steps_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [LEN_W-1:0]   k_q, k_d;
  logic signed [LEN_W:0] i_q, i_d;
  logic [LEN_W:0]     j_q, j_d;
  logic               phase_q, phase_d;
  logic               first_q, first_d;
  pos_t               pi_q, pi_d, pj_q, pj_d, key_q, key_d;
  logic [HASH_AW-1:0] haddr_q, haddr_d;

  // Result fields.
  status_e           status_q, status_d;
  logic [SYM_W-1:0]  inv_q, inv_d;
  logic [CODE_W-1:0] rdd_q, rdd_d;
  logic              m_valid_q, m_valid_d;
  logic [9:0]        m_data_q, m_data_d;

  // Memory ports.
  logic               step_we;
  logic [STEP_AW-1:0] step_waddr, step_raddr;
  logic [CODE_W-1:0]  step_wdata, step_rdata;
  logic               hash_we;
  logic [HASH_AW-1:0] hash_waddr;
  logic [HENT_W-1:0]  hash_wdata, hash_rdata;

  logic [LEN_W-1:0]   len;
  logic               load_ok;
  logic               back_ok, fwd_ok;
  logic               slot_empty, slot_hit;
  logic [EPOCH_W-1:0] epoch_inc;

  assign len = (wlen_q > LEN_W'(MAX_STEPS)) ? LEN_W'(MAX_STEPS) : wlen_q;
  assign load_ok = ({1'b0, idx_q} < len) && (sym_count(dim_q) != '0) &&
                   ({1'b0, dir_q} < {dim_q, 1'b0});
  assign back_ok = !i_q[LEN_W];
  assign fwd_ok  = j_q < {1'b0, len};
  assign slot_empty = hash_rdata[HENT_W-1 -: EPOCH_W] != epoch_q;
  assign slot_hit   = !slot_empty && (hash_rdata[KEY_W-1:0] == key_q);
  assign epoch_inc  = epoch_q + EPOCH_W'(1);

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_data_q};

  // Next state and register updates.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    dir_d       = dir_q;
    sym_d       = sym_q;
    clr_d       = clr_q;
    clr_steps_d = clr_steps_q;
    epoch_d     = epoch_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    phase_d     = phase_q;
    first_d     = first_q;
    pi_d        = pi_q;
    pj_d        = pj_q;
    key_d       = key_q;
    haddr_d     = haddr_q;
    status_d    = status_q;
    inv_d       = inv_q;
    rdd_d       = rdd_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;
    case (state_q)
      S_CLR: begin
        clr_d = clr_q + HASH_AW'(1);
        if (clr_q == '1) begin
          clr_steps_d = 1'b0;
          epoch_d     = EPOCH_W'(1);
          state_d     = clr_steps_q ? S_IDLE : S_HASH;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = op_e'(s_axis_tdata[1:0]);
          idx_d   = s_axis_tdata[9:2];
          dir_d   = s_axis_tdata[12:10];
          sym_d   = s_axis_tdata[17:13];
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        status_d = ST_INVALID;
        inv_d    = '0;
        rdd_d    = '0;
        state_d  = S_DONE;
        case (op_q)
          OP_LOAD: begin
            if (load_ok) begin
              status_d = ST_OK;
            end
          end
          OP_READ: begin
            if ({1'b0, idx_q} < len) begin
              state_d = S_RD_WAIT;
            end
          end
          OP_TRIAL: begin
            if (({1'b0, idx_q} < len) && (sym_q < sym_count(dim_q))) begin
              k_d     = '0;
              state_d = S_SCAN_RD;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_RD_WAIT: begin
        rdd_d    = step_rdata;
        status_d = ST_OK;
        state_d  = S_DONE;
      end
      S_SCAN_RD: state_d = S_SCAN_CK;
      S_SCAN_CK: begin
        if ({1'b0, step_rdata} >= {dim_q, 1'b0}) begin
          state_d = S_DONE;
        end else if (k_q + LEN_W'(1) == len) begin
          // All steps belong to this dimension: start the walk at the pivot.
          inv_d   = inv_sym(dim_q, sym_q);
          pi_d    = '0;
          pj_d    = '0;
          key_d   = '0;
          first_d = 1'b1;
          phase_d = 1'b0;
          i_d     = $signed({{(LEN_W + 1 - STEP_AW){1'b0}}, idx_q}) -
                    $signed((LEN_W + 1)'(1));
          j_d     = {{(LEN_W + 1 - STEP_AW){1'b0}}, idx_q};
          epoch_d = epoch_inc;
          state_d = (epoch_inc == '0) ? S_CLR : S_HASH;
        end else begin
          k_d     = k_q + LEN_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_HASH: begin
        haddr_d = hash_key(key_q);
        state_d = S_P_RD;
      end
      S_P_RD: state_d = S_P_CK;
      S_P_CK: begin
        if (slot_hit) begin
          status_d = ST_OVERLAP;
          state_d  = S_DONE;
        end else if (slot_empty) begin
          state_d = S_WSEL;
          if (first_q) begin
            first_d = 1'b0;
          end else if (!phase_q) begin
            phase_d = 1'b1;
          end else begin
            phase_d = 1'b0;
            i_d     = i_q - $signed((LEN_W + 1)'(1));
            j_d     = j_q + (LEN_W + 1)'(1);
          end
        end else begin
          haddr_d = haddr_q + HASH_AW'(1);
          state_d = S_P_RD;
        end
      end
      S_WSEL: begin
        if (!phase_q) begin
          if (!back_ok && !fwd_ok) begin
            k_d     = {1'b0, idx_q};
            state_d = S_C_RD;
          end else if (back_ok) begin
            state_d = S_WMOVE;
          end else begin
            phase_d = 1'b1;
          end
        end else begin
          if (fwd_ok) begin
            state_d = S_WMOVE;
          end else begin
            phase_d = 1'b0;
            i_d     = i_q - $signed((LEN_W + 1)'(1));
            j_d     = j_q + (LEN_W + 1)'(1);
          end
        end
      end
      S_WMOVE: begin
        if (!phase_q) begin
          pi_d  = move_pos(pi_q, step_rdata, 1'b1);
          key_d = move_pos(pi_q, step_rdata, 1'b1);
        end else begin
          pj_d  = move_pos(pj_q, map_step(dim_q, sym_q, step_rdata), 1'b0);
          key_d = move_pos(pj_q, map_step(dim_q, sym_q, step_rdata), 1'b0);
        end
        state_d = S_HASH;
      end
      S_C_RD: state_d = S_C_WR;
      S_C_WR: begin
        k_d = k_q + LEN_W'(1);
        if (k_q + LEN_W'(1) == len) begin
          status_d = ST_OK;
          state_d  = S_DONE;
        end else begin
          state_d = S_C_RD;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = {rdd_q, inv_q, status_q};
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    step_we    = 1'b0;
    step_waddr = idx_q;
    step_wdata = dir_q;
    step_raddr = idx_q;
    hash_we    = 1'b0;
    hash_waddr = haddr_q;
    hash_wdata = {epoch_q, key_q};
    case (state_q)
      S_CLR: begin
        step_we    = clr_steps_q && (clr_q < HASH_AW'(MAX_STEPS));
        step_waddr = clr_q[STEP_AW-1:0];
        step_wdata = '0;
        hash_we    = 1'b1;
        hash_waddr = clr_q;
        hash_wdata = '0;
      end
      S_EXEC: step_we = (op_q == OP_LOAD) && load_ok;
      S_SCAN_RD, S_C_RD: step_raddr = k_q[STEP_AW-1:0];
      S_WSEL: step_raddr = phase_q ? j_q[STEP_AW-1:0] : i_q[STEP_AW-1:0];
      S_P_CK: hash_we = slot_empty;
      S_C_WR: begin
        step_we    = 1'b1;
        step_waddr = k_q[STEP_AW-1:0];
        step_wdata = map_step(dim_q, sym_q, step_rdata);
      end
      default: step_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      clr_steps_q <= 1'b1;
      epoch_q     <= '0;
      m_valid_q   <= 1'b0;
      dim_q       <= DIM_W'(2);
      wlen_q      <= LEN_W'(MAX_STEPS);
      phase_q     <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      clr_steps_q <= clr_steps_d;
      epoch_q     <= epoch_d;
      m_valid_q   <= m_valid_d;
      phase_q     <= phase_d;
      first_q     <= first_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_DIMENSION:   dim_q  <= cfg_data_i[DIM_W-1:0];
          CFG_WALK_LENGTH: wlen_q <= cfg_data_i;
          default:         dim_q  <= dim_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    dir_q    <= dir_d;
    sym_q    <= sym_d;
    k_q      <= k_d;
    i_q      <= i_d;
    j_q      <= j_d;
    pi_q     <= pi_d;
    pj_q     <= pj_d;
    key_q    <= key_d;
    haddr_q  <= haddr_d;
    status_q <= status_d;
    inv_q    <= inv_d;
    rdd_q    <= rdd_d;
    m_data_q <= m_data_d;
  end

  spmc_ram #(
    .WIDTH(CODE_W),
    .DEPTH(MAX_STEPS)
  ) u_step_ram (
    .clk_i  (clk_i),
    .we_i   (step_we),
    .waddr_i(step_waddr),
    .wdata_i(step_wdata),
    .raddr_i(step_raddr),
    .rdata_o(step_rdata)
  );

  spmc_ram #(
    .WIDTH(HENT_W),
    .DEPTH(HASH_DEPTH)
  ) u_hash_ram (
    .clk_i  (clk_i),
    .we_i   (hash_we),
    .waddr_i(hash_waddr),
    .wdata_i(hash_wdata),
    .raddr_i(haddr_q),
    .rdata_o(hash_rdata)
  );

`ifndef SYNTHESIS
  // The walk is only rewritten by a clearing pass, a load or a commit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_we |-> (state_q == S_CLR || state_q == S_EXEC || state_q == S_C_WR))
    else $error("step memory written outside clear, load or commit");

  // Epoch zero marks free table slots and is never the live epoch of a probe.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P_RD || state_q == S_P_CK) |-> epoch_q != '0)
    else $error("hash probe with epoch zero");

  // An accepted word always starts execution.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> state_q == S_EXEC)
    else $error("accepted word did not start execution");

  // A result is loaded only from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == S_DONE)
    else $error("result raised outside the final state");
`endif

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pivot move checker. A scoreboard class predicts
// loads, reads and pivot trials on its own copy of the walk and checks every
// result word in order, under random idling and backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

// Scoreboard: holds the predicted walk and the queue of expected results.
class pivot_scoreboard;
  logic [2:0]  walk_q [256];
  logic [2:0]  dim;
  logic [8:0]  wlen;
  logic [9:0]  pending_status [$];
  int          errors;

  function void clear();
    for (int k = 0; k < 256; k++) walk_q[k] = '0;
    dim = 3'd2;
    wlen = 9'd256;
    errors = 0;
  endfunction

  function int sym_limit();
    case (dim)
      3'd2: return 4;
      3'd3: return 12;
      3'd4: return 22;
      default: return 0;
    endcase
  endfunction

  // Positive-step code per axis for each symmetry, written out per dimension.
  function logic [2:0] map_code(int sym, logic [2:0] code);
    int m2 [4][4] = '{'{0,3,0,0},'{1,2,0,0},'{3,0,0,0},'{2,1,0,0}};
    int m3 [12][4] = '{'{0,2,5,0},'{1,2,4,0},'{0,3,4,0},'{0,5,2,0},'{0,3,5,0},
      '{0,4,3,0},'{5,2,0,0},'{1,2,5,0},'{4,2,1,0},'{2,1,4,0},'{1,3,4,0},'{3,0,4,0}};
    int m4 [22][4] = '{'{0,2,4,7},'{0,2,5,6},'{0,3,4,6},'{1,2,4,6},'{0,2,7,4},
      '{0,2,5,7},'{0,2,6,5},'{0,7,4,2},'{0,3,4,7},'{0,6,4,3},'{0,5,2,6},
      '{0,3,5,6},'{0,4,3,6},'{7,2,4,0},'{1,2,4,7},'{6,2,4,1},'{5,2,0,6},
      '{1,2,5,6},'{4,2,1,6},'{3,0,4,6},'{1,3,4,6},'{2,1,4,6}};
    int ax;
    int b;
    ax = code[2:1];
    if (dim == 3'd2) b = m2[sym % 4][ax];
    else if (dim == 3'd3) b = m3[sym < 12 ? sym : 0][ax];
    else b = m4[sym < 22 ? sym : 0][ax];
    return 3'(b) ^ {2'b00, code[0]};
  endfunction

  function logic [4:0] inverse_of(int sym);
    int i2 [4] = '{0,1,3,2};
    int i3 [12] = '{0,1,2,5,4,3,8,7,6,11,10,9};
    int i4 [22] = '{0,1,2,3,6,5,4,9,8,7,12,11,10,15,14,13,18,17,16,21,20,19};
    if (dim == 3'd2) return 5'(i2[sym % 4]);
    if (dim == 3'd3) return 5'(i3[sym]);
    return 5'(i4[sym]);
  endfunction

  function logic [39:0] site_key(logic [9:0] p [4]);
    return {p[3], p[2], p[1], p[0]};
  endfunction

  function void step_site(ref logic [9:0] p [4], input logic [2:0] code, input bit back);
    if (code[0] ^ back) p[code[2:1]] = p[code[2:1]] - 10'd1;
    else p[code[2:1]] = p[code[2:1]] + 10'd1;
  endfunction

  // Returns the trial status; commits the transformed steps on success.
  function logic [1:0] pivot_trial(int idx, int sym, int len);
    logic [9:0]  pb [4];
    logic [9:0]  pf [4];
    bit          seen [logic [39:0]];
    int          i;
    int          j;
    for (int a = 0; a < 4; a++) begin
      pb[a] = '0;
      pf[a] = '0;
    end
    seen[site_key(pb)] = 1;
    i = idx - 1;
    j = idx;
    while (i >= 0 || j < len) begin
      if (i >= 0) begin
        step_site(pb, walk_q[i], 1'b1);
        if (seen.exists(site_key(pb))) return 2'd1;
        seen[site_key(pb)] = 1;
      end
      if (j < len) begin
        step_site(pf, map_code(sym, walk_q[j]), 1'b0);
        if (seen.exists(site_key(pf))) return 2'd1;
        seen[site_key(pf)] = 1;
      end
      i--;
      j++;
    end
    for (int k = idx; k < len; k++) walk_q[k] = map_code(sym, walk_q[k]);
    return 2'd0;
  endfunction

  function void note_word(logic [1:0] op, logic [7:0] idx, logic [2:0] dir,
                          logic [4:0] sym);
    int len;
    int ns;
    logic [1:0] st;
    logic [4:0] inv;
    logic [2:0] rd;
    bit ok;
    len = (wlen > 256) ? 256 : wlen;
    ns = sym_limit();
    st = spmc_pkg::ST_INVALID;
    inv = '0;
    rd = '0;
    if (op == spmc_pkg::OP_LOAD) begin
      if (idx < len && ns != 0 && dir < 2 * dim) begin
        walk_q[idx] = dir;
        st = spmc_pkg::ST_OK;
      end
    end else if (op == spmc_pkg::OP_READ) begin
      if (idx < len) begin
        rd = walk_q[idx];
        st = spmc_pkg::ST_OK;
      end
    end else if (op == spmc_pkg::OP_TRIAL) begin
      ok = idx < len && sym < ns;
      for (int k = 0; ok && k < len; k++) if (walk_q[k] >= 2 * dim) ok = 0;
      if (ok) begin
        inv = inverse_of(sym);
        st = pivot_trial(idx, sym, len);
      end
    end
    pending_status.insert(pending_status.size(), {rd, inv, st});
  endfunction

  function void check_word(logic [15:0] data);
    logic [9:0] e;
    if (pending_status.size() == 0) begin
      $error("result word with nothing expected: %h", data);
      errors++;
      return;
    end
    e = pending_status.pop_front();
    if (data[1:0] !== e[1:0]) begin
      $error("status: expected %0d, got %0d", e[1:0], data[1:0]);
      errors++;
    end
    if (data[6:2] !== e[6:2]) begin
      $error("inverse_symmetry: expected %0d, got %0d", e[6:2], data[6:2]);
      errors++;
    end
    if (data[9:7] !== e[9:7]) begin
      $error("read_direction: expected %0d, got %0d", e[9:7], data[9:7]);
      errors++;
    end
  endfunction
endclass

module tb;
  import spmc_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [8:0]  cfg_data_i;

  pivot_scoreboard sb;
  // Idle percentages for sender and receiver, changed between phases.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // When set, the receiver process deasserts tready for a long stretch.
  bit          hold_request;
  longint      cycle_count;

  saw_pivot_move_checker dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Global watchdog; the count covers the clearing pass too.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic bit m_axis_valid_accept();
    return m_axis_tvalid && m_axis_tready;
  endfunction

  // Result monitor: every accepted result word goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_valid_accept()) sb.check_word(m_axis_tdata);
  end

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_request = 0;
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sends one word: optional idle gap, then hold tvalid until accepted.
  // tvalid stays high after acceptance until an idle cycle or drain drops it.
  task automatic send_word(logic [1:0] op, logic [7:0] idx, logic [2:0] dir,
                           logic [4:0] sym);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {6'd0, sym, dir, idx, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(op, idx, dir, sym);
  endtask

  // Waits until every expected result has arrived, then lets the block settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] which, logic [8:0] value);
    cfg_index_i <= which;
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (which == CFG_DIMENSION) sb.dim = value[2:0];
    else sb.wlen = value;
    @(posedge clk_i);
  endtask

  // Loads a random self-avoiding-friendly walk: mostly straight, some turns.
  task automatic load_walk(int len, int d);
    for (int k = 0; k < len; k++) begin
      send_word(OP_LOAD, 8'(k),
                ($urandom_range(3) == 0) ? 3'($urandom_range(2 * d - 1)) : 3'd0, 5'd0);
    end
  endtask

  // One random item: mostly valid trials and reads, some noise.
  task automatic random_word(int len, int d);
    int r;
    r = $urandom_range(99);
    if (r < 45)
      send_word(OP_TRIAL, 8'($urandom_range(len - 1)), 3'($urandom),
                5'($urandom_range(sb.sym_limit() - 1)));
    else if (r < 65)
      send_word(OP_READ, 8'($urandom_range(len - 1)), 3'($urandom), 5'($urandom));
    else if (r < 80)
      send_word(OP_LOAD, 8'($urandom_range(len - 1)),
                3'($urandom_range(2 * d - 1)), 5'($urandom));
    else
      send_word(2'($urandom), 8'($urandom), 3'($urandom), 5'($urandom));
  endtask

  initial begin
    int dims [3] = '{2, 3, 4};
    int lens [4] = '{1, 8, 24, 256};
    int len;
    int d;
    sb = new();
    sb.clear();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    hold_request  = 0;
    send_idle_pct = 25;
    recv_idle_pct = 83;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset walk: straight line, full length.
    send_word(OP_READ, 8'd255, 3'd0, 5'd0);
    send_word(OP_TRIAL, 8'd0, 3'd0, 5'd3);
    send_word(OP_TRIAL, 8'd128, 3'd0, 5'd4);      // symmetry out of range
    send_word(OP_NONE, 8'd5, 3'd7, 5'd31);        // unused operation
    send_word(OP_LOAD, 8'd3, 3'd4, 5'd0);         // direction too large
    send_word(OP_LOAD, 8'd3, 3'd3, 5'd0);
    send_word(OP_READ, 8'd3, 3'd0, 5'd0);
    send_word(OP_TRIAL, 8'd255, 3'd0, 5'd2);
    drain();
    // Short walk: an index at the end is out of range; a U-turn overlaps.
    write_reg(CFG_WALK_LENGTH, 9'd4);
    send_word(OP_READ, 8'd4, 3'd0, 5'd0);
    send_word(OP_LOAD, 8'd0, 3'd0, 5'd0);
    send_word(OP_LOAD, 8'd1, 3'd2, 5'd0);
    send_word(OP_LOAD, 8'd2, 3'd1, 5'd0);
    send_word(OP_LOAD, 8'd3, 3'd0, 5'd0);
    send_word(OP_TRIAL, 8'd2, 3'd0, 5'd1);
    drain();
    // Bad dimension: loads and trials refuse, reads still work.
    write_reg(CFG_DIMENSION, 3'd7);
    send_word(OP_LOAD, 8'd0, 3'd0, 5'd0);
    send_word(OP_TRIAL, 8'd1, 3'd0, 5'd0);
    send_word(OP_READ, 8'd1, 3'd0, 5'd0);
    drain();
    // Foreign steps: load axis 3 in dimension 4, then trial in dimension 2.
    write_reg(CFG_DIMENSION, 3'd4);
    send_word(OP_LOAD, 8'd1, 3'd7, 5'd0);
    send_word(OP_TRIAL, 8'd0, 3'd0, 5'd21);
    drain();
    write_reg(CFG_DIMENSION, 3'd2);
    send_word(OP_TRIAL, 8'd0, 3'd0, 5'd1);
    drain();
    write_reg(CFG_WALK_LENGTH, 9'd0);             // empty walk
    send_word(OP_READ, 8'd0, 3'd0, 5'd0);
    drain();

    // Random part in phases of idling and settings.
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 83;
        recv_idle_pct = 25;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      d = dims[ph % 3];
      len = (ph == 11) ? 256 : lens[$urandom_range(2)];
      write_reg(CFG_DIMENSION, 3'(d));
      write_reg(CFG_WALK_LENGTH, 9'(len));
      load_walk(len, d);
      if (ph == 9) hold_request = 1;
      for (int n = 0; n < ((ph == 11) ? 20 : 70); n++) random_word(len, d);
      drain();
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_status.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/spmc_pkg.sv
rtl/core/spmc_ram.sv
rtl/core/saw_pivot_move_checker.sv
dv/tb.sv
